// ===== src/vn_pkg.sv =====
// Package for the vector normalize unit: shared widths, register indexes and lane types.
// Depends on nothing; used by every module in src.
`default_nettype none
package vn_pkg;
  localparam int MagW = 32;
  localparam int SumW = 68;
  localparam int RootW = 35;
  localparam int QOne = 30;
  localparam int NumW = 62;
  localparam int OutW = 32;

  typedef enum logic [0:0] {
    REG_ACTIVE = 1'b0,
    REG_MIN_NORM = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic valid;
    logic [RootW-1:0] d;
  } div_ctl_t;
endpackage
`default_nettype wire

// ===== src/vn_sqrt.sv =====
// Pipelined integer square root, one result bit per stage, with the minimum norm floor.
// Depends on vn_pkg.
`default_nettype none
module vn_sqrt
  import vn_pkg::*;
  (
    input  wire logic              clk,
    input  wire logic              rst,
    input  wire logic              in_valid,
    input  wire logic [SumW-1:0]   sum,
    input  wire logic [30:0]       min_norm,
    output div_ctl_t               ctl
  );
  localparam int St = RootW;

  logic [St:0]            v;
  logic [SumW-1:0]        rem [St+1];
  logic [RootW-1:0]       root [St+1];
  logic [30:0]            mn [St+1];
  logic [RootW-1:0]       dsel;

  assign v[0] = in_valid;
  assign rem[0] = sum;
  assign root[0] = '0;
  assign mn[0] = min_norm;

  for (genvar s = 0; s < St; s++) begin : g_st
    localparam int B = St - 1 - s;
    logic [SumW+1:0] trial;
    logic [SumW+1:0] rx;
    always_comb begin
      trial = ({{(SumW+2-RootW){1'b0}}, root[s]} << (B + 1))
            | ((SumW+2)'(1) << (2 * B));
      rx = {2'b00, rem[s]};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        v[s+1] <= 1'b0;
      end else begin
        v[s+1] <= v[s];
      end
      mn[s+1] <= mn[s];
      if (trial <= rx) begin
        rem[s+1] <= SumW'(rx - trial);
        root[s+1] <= root[s] | (RootW'(1) << B);
      end else begin
        rem[s+1] <= rem[s];
        root[s+1] <= root[s];
      end
    end
  end

  always_comb begin
    dsel = root[St];
    if (dsel < {4'd0, mn[St]}) begin
      dsel = {4'd0, mn[St]};
    end
    if (dsel == '0) begin
      dsel = RootW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else begin
      ctl.valid <= v[St];
    end
    ctl.d <= dsel;
  end
endmodule
`default_nettype wire

// ===== src/vn_lane.sv =====
// One division lane: restoring divider pipelined one quotient bit per stage, with sign.
// Depends on vn_pkg.
`default_nettype none
module vn_lane
  import vn_pkg::*;
  (
    input  wire logic              clk,
    input  wire logic [MagW-1:0]   mag,
    input  wire logic              neg,
    input  wire logic              active,
    input  wire div_ctl_t          ctl,
    output logic [OutW-1:0]        unit
  );
  localparam int Qb = QOne + 2;
  localparam int Rw = NumW + 1;

  logic [Rw-1:0]     rem [Qb+1];
  logic [Qb-1:0]     q [Qb+1];
  logic [RootW-1:0]  d [Qb+1];
  logic              sg [Qb+1];
  logic              act [Qb+1];
  logic [Qb-1:0]     qs;

  always_comb begin
    rem[0] = Rw'({mag, {QOne{1'b0}}}) + Rw'(ctl.d >> 1);
    q[0] = '0;
    d[0] = ctl.d;
    sg[0] = neg;
    act[0] = active;
  end

  for (genvar s = 0; s < Qb; s++) begin : g_st
    localparam int B = Qb - 1 - s;
    logic [Rw+RootW-1:0] dv;
    always_comb dv = {{Rw{1'b0}}, d[s]} << B;
    always_ff @(posedge clk) begin
      d[s+1] <= d[s];
      sg[s+1] <= sg[s];
      act[s+1] <= act[s];
      if (dv <= {{RootW{1'b0}}, rem[s]}) begin
        rem[s+1] <= Rw'({{RootW{1'b0}}, rem[s]} - dv);
        q[s+1] <= q[s] | (Qb'(1) << B);
      end else begin
        rem[s+1] <= rem[s];
        q[s+1] <= q[s];
      end
    end
  end

  always_comb begin
    qs = q[Qb];
    if (qs > (Qb'(1) << QOne)) begin
      qs = Qb'(1) << QOne;
    end
    if (!act[Qb]) begin
      unit = '0;
    end else if (sg[Qb]) begin
      unit = OutW'(-qs);
    end else begin
      unit = OutW'(qs);
    end
  end
endmodule
`default_nettype wire

// ===== src/vector_normalize_unit.sv =====
// Top level of the vector normalize unit: registers, squaring lanes, root and division lanes.
// Depends on vn_pkg, vn_sqrt and vn_lane.
//
// Usage: drive comp_0..comp_N with start high; busy is always low, so one word is taken
// every cycle. Each word returns exactly one result word, marked by done for one cycle,
// with unit_0..unit_N as signed Q1.30 fractions, zero for inactive components.
// A word passes the input register, the squaring register and adder, the bit-per-stage
// square root and floor, the bit-per-stage division lanes and the output register.
// Throughput is one word per cycle; the root and divider stages set the pipeline depth.
// The APB port holds active_components at 0x0 and min_norm at 0x4; write only while idle.
// Reset (synchronous, rst high) empties the pipeline and sets active_components to 3 and
// min_norm to 1. The receiver cannot stall: results must be taken when done is high.
`default_nettype none
module vector_normalize_unit
  import vn_pkg::*;
  #(
    parameter int MAX_COMPONENTS = 4,
    parameter int DATA_WIDTH = 32
  ) (
    input  wire logic                   clk,
    input  wire logic                   rst,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic [DATA_WIDTH-1:0]  comp_0,
    input  wire logic [DATA_WIDTH-1:0]  comp_1,
    input  wire logic [DATA_WIDTH-1:0]  comp_2,
    input  wire logic [DATA_WIDTH-1:0]  comp_3,
    output logic                        done,
    output logic [OutW-1:0]             unit_0,
    output logic [OutW-1:0]             unit_1,
    output logic [OutW-1:0]             unit_2,
    output logic [OutW-1:0]             unit_3,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [2:0]             paddr,
    input  wire logic [31:0]            pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
  );
  localparam int Nc = 4;
  localparam int InW = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
  localparam int DivLat = QOne + 2;
  localparam int PreLat = RootW + 1;

  logic [2:0]  active_components;
  logic [30:0] min_norm;
  reg_idx_t    widx;
  logic [2:0]  n_eff;

  assign pready = 1'b1;
  assign busy = 1'b0;
  assign widx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      active_components <= 3'd3;
      min_norm <= 31'd1;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      case (widx)
        REG_ACTIVE:   active_components <= pwdata[2:0];
        REG_MIN_NORM: min_norm <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_ACTIVE:   prdata = {29'd0, active_components};
      REG_MIN_NORM: prdata = {1'b0, min_norm};
      default:      prdata = '0;
    endcase
  end

  always_comb begin
    n_eff = (32'(active_components) > MAX_COMPONENTS) ? 3'(MAX_COMPONENTS) : active_components;
  end

  logic [DATA_WIDTH-1:0] comp [Nc];
  assign comp[0] = comp_0;
  assign comp[1] = comp_1;
  assign comp[2] = comp_2;
  assign comp[3] = comp_3;

  logic            v1, v2;
  logic [MagW-1:0] mag1 [Nc];
  logic            neg1 [Nc];
  logic            act1 [Nc];
  logic [63:0]     sq2 [Nc];
  logic [SumW-1:0] sum2;
  logic [MagW-1:0] magp [PreLat+1][Nc];
  logic            negp [PreLat+1][Nc];
  logic            actp [PreLat+1][Nc];
  div_ctl_t        ctl;
  logic [DivLat:0] vd;
  logic [OutW-1:0] unit_w [Nc];

  for (genvar i = 0; i < Nc; i++) begin : g_in
    logic signed [InW-1:0] c;
    assign c = InW'(comp[i]);
    always_ff @(posedge clk) begin
      neg1[i] <= c[InW-1];
      mag1[i] <= c[InW-1] ? MagW'(-{{(33-InW){c[InW-1]}}, c}) : MagW'(c);
      act1[i] <= (i < MAX_COMPONENTS) && (3'(i) < n_eff);
      sq2[i] <= act1[i] ? (64'(mag1[i]) * 64'(mag1[i])) : 64'd0;
      magp[0][i] <= mag1[i];
      negp[0][i] <= neg1[i];
      actp[0][i] <= act1[i];
    end
  end

  always_comb begin
    sum2 = SumW'(sq2[0]) + SumW'(sq2[1]) + SumW'(sq2[2]) + SumW'(sq2[3]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
    end
  end

  for (genvar s = 0; s < PreLat; s++) begin : g_dly
    always_ff @(posedge clk) begin
      magp[s+1] <= magp[s];
      negp[s+1] <= negp[s];
      actp[s+1] <= actp[s];
    end
  end

  vn_sqrt u_sqrt (
    .clk(clk), .rst(rst), .in_valid(v2), .sum(sum2), .min_norm(min_norm), .ctl(ctl)
  );

  for (genvar i = 0; i < Nc; i++) begin : g_lane
    vn_lane u_lane (
      .clk(clk), .mag(magp[PreLat][i]), .neg(negp[PreLat][i]),
      .active(actp[PreLat][i]), .ctl(ctl), .unit(unit_w[i])
    );
  end

  assign vd[0] = ctl.valid;
  always_ff @(posedge clk) begin
    if (rst) begin
      vd[DivLat:1] <= '0;
      done <= 1'b0;
    end else begin
      vd[DivLat:1] <= vd[DivLat-1:0];
      done <= vd[DivLat];
    end
    unit_0 <= unit_w[0];
    unit_1 <= unit_w[1];
    unit_2 <= unit_w[2];
    unit_3 <= unit_w[3];
  end

`ifndef ASSERT_OFF
  a_busy_low: assert property (@(posedge clk) busy == 1'b0)
    else $error("busy raised");
  a_ready: assert property (@(posedge clk) pready)
    else $error("pready low");
  a_no_done_after_reset: assert property (@(posedge clk) $past(rst) |-> !done)
    else $error("done after reset");
  a_floor_nonzero: assert property (@(posedge clk) disable iff (rst)
    ctl.valid |-> ctl.d != '0)
    else $error("zero divisor");
`endif
endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for vector_normalize_unit: drives vectors and APB writes,
// predicts each normalized word and compares it with the block's output.
// Depends on vn_pkg and the RTL under src.
`timescale 1ns / 1ps
module tb
  import vn_pkg::*;
();

  localparam int Latency = 71;
  localparam int WatchLimit = 4000;

  typedef struct {
    logic [31:0] u0, u1, u2, u3;
  } unit_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [31:0] comp_0 = '0, comp_1 = '0, comp_2 = '0, comp_3 = '0;
  logic done;
  logic [31:0] unit_0, unit_1, unit_2, unit_3;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  unit_word_t expected_units[$];
  logic [2:0] model_active;
  logic [30:0] model_min_norm;
  int idle_pct;
  int mismatches;
  int words_sent;
  int words_checked;
  int idle_cycles;

  vector_normalize_unit i_dut (
    .clk, .rst, .start, .busy, .comp_0, .comp_1, .comp_2, .comp_3,
    .done, .unit_0, .unit_1, .unit_2, .unit_3,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #1 clk = ~clk;

  function automatic logic [67:0] square_sum(input logic [31:0] m[4], input int n);
    logic [67:0] s;
    s = '0;
    for (int i = 0; i < n; i++) s += 68'(m[i]) * 68'(m[i]);
    return s;
  endfunction

  function automatic logic [34:0] int_root(input logic [67:0] s);
    logic [34:0] r, t;
    r = '0;
    for (int b = 34; b >= 0; b--) begin
      t = r | (35'd1 << b);
      if (70'(t) * 70'(t) <= 70'(s)) r = t;
    end
    return r;
  endfunction

  function automatic unit_word_t normalize(input logic [31:0] c[4]);
    logic [31:0] m[4];
    logic neg[4];
    logic [31:0] q[4];
    logic [34:0] d;
    logic [67:0] num;
    logic [67:0] quo;
    int n;
    unit_word_t w;
    n = (model_active > 4) ? 4 : int'(model_active);
    for (int i = 0; i < 4; i++) begin
      neg[i] = c[i][31];
      m[i] = neg[i] ? -c[i] : c[i];
      q[i] = '0;
    end
    d = int_root(square_sum(m, n));
    if (d < 35'(model_min_norm)) d = 35'(model_min_norm);
    if (d == 0) d = 35'd1;
    for (int i = 0; i < n; i++) begin
      num = (68'(m[i]) << QOne) + 68'(d >> 1);
      quo = num / 68'(d);
      if (quo > (68'd1 << QOne)) quo = 68'd1 << QOne;
      q[i] = neg[i] ? -quo[31:0] : quo[31:0];
    end
    w.u0 = q[0];
    w.u1 = q[1];
    w.u2 = q[2];
    w.u3 = q[3];
    return w;
  endfunction

  task automatic send_vector(input logic [31:0] a, b, c, d);
    logic [31:0] v[4];
    v[0] = a;
    v[1] = b;
    v[2] = c;
    v[3] = d;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    comp_0 <= a;
    comp_1 <= b;
    comp_2 <= c;
    comp_3 <= d;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_units = {expected_units, normalize(v)};
    words_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_units.size() != 0) @(posedge clk);
    repeat (Latency + 8) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(idx) << 2;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    if (idx == REG_ACTIVE) model_active = value[2:0];
    else model_min_norm = value[30:0];
  endtask

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($urandom_range(7)) - 32'd3;
      3: return 32'($urandom_range(2000)) - 32'd1000;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    write_reg(REG_ACTIVE, 32'd4);
    send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vector(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_vector(32'h8000_0000, 32'h0, 32'h0, 32'h0);
    send_vector(32'h0, 32'h0, 32'h0, 32'h0);
    send_vector(32'd3, 32'd4, 32'd0, 32'd0);
    send_vector(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'd1);
    send_vector(32'd1, 32'd1, 32'd1, 32'd0);
    drain();
    write_reg(REG_MIN_NORM, 32'h7FFF_FFFF);
    send_vector(32'd5, 32'hFFFF_FFF0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_vector(32'd0, 32'd0, 32'd0, 32'd0);
    drain();
    write_reg(REG_MIN_NORM, 32'd0);
    send_vector(32'd0, 32'd0, 32'd0, 32'd0);
    send_vector(32'd7, 32'd0, 32'd0, 32'd0);
    drain();
    write_reg(REG_ACTIVE, 32'd0);
    send_vector(32'd9, 32'd9, 32'd9, 32'd9);
    drain();
    write_reg(REG_ACTIVE, 32'd7);
    send_vector(32'd1, 32'd2, 32'd3, 32'd4);
    send_vector(32'hFFFF_FFFE, 32'd2, 32'hFFFF_FFFE, 32'd2);
    drain();
    write_reg(REG_ACTIVE, 32'd1);
    write_reg(REG_MIN_NORM, 32'd1);
    send_vector(32'h8000_0000, 32'd5, 32'd5, 32'd5);
    send_vector(32'hFFFF_FFFF, 32'd5, 32'd5, 32'd5);
    drain();
  endtask

  task automatic test_random(input int count, input int pct);
    idle_pct = pct;
    for (int i = 0; i < count; i++) begin
      send_vector(rand_comp(), rand_comp(), rand_comp(), rand_comp());
      if (i == count / 2) begin
        start <= 1'b0;
        while (expected_units.size() != 0) @(posedge clk);
      end
    end
    drain();
  endtask

  task automatic test_settings();
    logic [31:0] mn;
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_ACTIVE, 32'($urandom_range(7)));
      case (ph % 3)
        0: mn = 32'($urandom_range(1, 100));
        1: mn = ($urandom >> 1) >> $urandom_range(30);
        default: mn = 32'h7FFF_FFFF;
      endcase
      write_reg(REG_MIN_NORM, mn);
      test_random(35, (ph % 2) ? 63 : 17);
    end
  endtask

  always @(posedge clk) begin
    unit_word_t w;
    if (!rst && done) begin
      words_checked++;
      if (expected_units.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word %h %h %h %h",
                                       unit_0, unit_1, unit_2, unit_3);
      end else begin
        w = expected_units.pop_front();
        if (w.u0 !== unit_0 || w.u1 !== unit_1 || w.u2 !== unit_2 || w.u3 !== unit_3) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected %h %h %h %h, got %h %h %h %h",
                     w.u0, w.u1, w.u2, w.u3, unit_0, unit_1, unit_2, unit_3);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy) || (psel && penable)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    mismatches = 0;
    words_sent = 0;
    words_checked = 0;
    idle_cycles = 0;
    idle_pct = 0;
    model_active = 3'd3;
    model_min_norm = 31'd1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_random(40, 0);
    test_directed();
    write_reg(REG_ACTIVE, 32'd4);
    test_random(80, 0);
    test_random(80, 63);
    test_random(60, 17);
    test_settings();
    write_reg(REG_ACTIVE, 32'd4);
    write_reg(REG_MIN_NORM, 32'd1);
    test_random(20, 0);
    if (expected_units.size() != 0) mismatches++;
    $display("Sent %0d words and checked %0d results over several register settings.",
             words_sent, words_checked);
    $display("Idle rates of 0, 17 and 63 percent were used, with %0d mismatches.", mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
src/vn_pkg.sv
src/vn_sqrt.sv
src/vn_lane.sv
src/vector_normalize_unit.sv
dv/tb.sv
